// ===== rtl/dssm_pkg.sv =====
// Package for the dual stack shared memory block.
// Holds command and status codes, payload structs and default sizes.
// No dependencies.
package dssm_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int WORD_BITS_DEF = 32;
	localparam int VALUE_W       = 32;

	typedef enum logic [1:0] {
		CMD_PUSH_A = 2'd0,
		CMD_PUSH_B = 2'd1,
		CMD_POP_A  = 2'd2,
		CMD_POP_B  = 2'd3
	} cmd_t;

	typedef logic [1:0] status_t;
	localparam status_t ST_DONE      = 2'd0;
	localparam status_t ST_OVERFLOW  = 2'd1;
	localparam status_t ST_UNDERFLOW = 2'd2;

	localparam logic signed [VALUE_W-1:0] UNDERFLOW_VALUE = -32'sd999;

	typedef struct packed {
		logic [1:0]                 command;
		logic signed [VALUE_W-1:0]  push_value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0]  pop_value;
		status_t                    status;
	} rsp_t;

	// Stage-one control handed from the stack controller to the output side
	typedef struct packed {
		logic    valid;
		logic    pop_ok;
		status_t status;
	} ctl_t;

endpackage

// ===== rtl/dssm_ram.sv =====
// Shared word memory for both stacks: one address port, registered read.
// Depends on nothing but its parameters.
module dssm_ram #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32,
	localparam int AW       = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic                 re,
	input  logic [AW-1:0]        addr,
	input  logic [WORD_BITS-1:0] wdata,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== rtl/dssm_ctrl.sv =====
// Stack controller: holds both stack counts, forms the memory address and
// the status of each command. Depends on dssm_pkg.
module dssm_ctrl import dssm_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	localparam int AW       = $clog2(DEPTH),
	localparam int CW       = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  req_t                 request,
	output logic                 full,
	output logic                 ram_we,
	output logic                 ram_re,
	output logic [AW-1:0]        ram_addr,
	output logic [WORD_BITS-1:0] ram_wdata,
	output ctl_t                 ctl
);

	localparam logic [CW-1:0] TOP_IDX   = CW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
	localparam logic [CW:0]   DEPTH_SUM = (CW + 1)'(DEPTH);

	logic [CW-1:0] cnt_a_q, cnt_b_q;
	logic [CW-1:0] cnt_a_d, cnt_b_d;
	logic [CW-1:0] idx;
	logic          pop_ok;
	status_t       status;
	logic          valid_s1;
	logic          pop_ok_s1;
	status_t       status_s1;
	cmd_t          cmd;

	assign cmd  = cmd_t'(request.command);
	assign full = ({1'b0, cnt_a_q} + {1'b0, cnt_b_q}) >= DEPTH_SUM;

	always_comb begin
		cnt_a_d = cnt_a_q;
		cnt_b_d = cnt_b_q;
		idx     = '0;
		ram_we  = 1'b0;
		pop_ok  = 1'b0;
		status  = ST_DONE;
		case (cmd)
			CMD_PUSH_A: begin
				idx = cnt_a_q;
				if (full) begin
					status = ST_OVERFLOW;
				end else begin
					ram_we  = start;
					cnt_a_d = cnt_a_q + 1'b1;
				end
			end
			CMD_PUSH_B: begin
				idx = TOP_IDX - cnt_b_q;
				if (full) begin
					status = ST_OVERFLOW;
				end else begin
					ram_we  = start;
					cnt_b_d = cnt_b_q + 1'b1;
				end
			end
			CMD_POP_A: begin
				idx = cnt_a_q - 1'b1;
				if (cnt_a_q == '0) begin
					status = ST_UNDERFLOW;
				end else begin
					pop_ok  = 1'b1;
					cnt_a_d = cnt_a_q - 1'b1;
				end
			end
			CMD_POP_B: begin
				idx = DEPTH_C - cnt_b_q;
				if (cnt_b_q == '0) begin
					status = ST_UNDERFLOW;
				end else begin
					pop_ok  = 1'b1;
					cnt_b_d = cnt_b_q - 1'b1;
				end
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	assign ram_re    = start & pop_ok;
	assign ram_addr  = idx[AW-1:0];
	assign ram_wdata = WORD_BITS'(unsigned'(request.push_value));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
		end else if (start) begin
			cnt_a_q <= cnt_a_d;
			cnt_b_q <= cnt_b_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	// payload of the stage, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			pop_ok_s1 <= pop_ok;
			status_s1 <= status;
		end
	end

	assign ctl = {valid_s1, pop_ok_s1, status_s1};

endmodule

// ===== rtl/dual_stack_shared_memory.sv =====
// Two stacks sharing one word memory: stack A grows up from word 0, stack B
// grows down from word DEPTH-1. A command is taken in every cycle (busy is
// never raised) and its one result appears on the result port with done high
// in the following cycle; that cycle is the registered read of the memory.
// The receiver cannot stall, so every result must be taken in its cycle.
// Depends on dssm_pkg, dssm_ctrl and dssm_ram.
module dual_stack_shared_memory import dssm_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output rsp_t result
);

	localparam int AW = $clog2(DEPTH);

	logic                        full;
	logic                        ram_we, ram_re;
	logic [AW-1:0]               ram_addr;
	logic [WORD_BITS-1:0]        ram_wdata;
	logic signed [WORD_BITS-1:0] ram_rdata;
	ctl_t                        ctl;

	dssm_ctrl #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.request   (request),
		.full      (full),
		.ram_we    (ram_we),
		.ram_re    (ram_re),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ctl       (ctl)
	);

	dssm_ram #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign busy = 1'b0;
	assign done = ctl.valid;

	// sign-extend the stored word, then keep the low bits of the result field
	always_comb begin
		result.status = ctl.status;
		if (ctl.pop_ok) begin
			result.pop_value = VALUE_W'(ram_rdata);
		end else if (ctl.status == ST_UNDERFLOW) begin
			result.pop_value = UNDERFLOW_VALUE;
		end else begin
			result.pop_value = '0;
		end
	end

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start))
		else $error("result strobe without a transfer one cycle earlier");

	a_push_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !full && (request.command == CMD_PUSH_A || request.command == CMD_PUSH_B))
		|=> (done && result.status == ST_DONE && result.pop_value == '0))
		else $error("push with room left did not complete");

	a_push_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(start && full && (request.command == CMD_PUSH_A || request.command == CMD_PUSH_B))
		|=> (done && result.status == ST_OVERFLOW))
		else $error("push into full memory not refused");

endmodule

// ===== tb/sv/dual_stack_shared_memory_test.sv =====
// Testbench for dual_stack_shared_memory: drives push/pop commands in bursts,
// predicts each result from its own model of the two stacks and checks it.
// Depends on dssm_pkg and the dual_stack_shared_memory RTL.
`timescale 1ns / 100ps

module dual_stack_shared_memory_test;
	import dssm_pkg::*;

	localparam int STACK_WORDS = DEPTH_DEF;
	localparam int WORD_W      = WORD_BITS_DEF;
	localparam int RANDOM_CMDS = 1250;

	typedef struct {
		req_t req;
		bit   drain_first;
	} stack_cmd_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	rsp_t result;

	stack_cmd_t command_queue[$];
	rsp_t       awaited_results[$];
	logic       taken = 1'b0;
	int         mismatch_count = 0;
	int         gap_left = 0;
	int         burst_left = 1;

	// Shadow of the shared array and both stack depths
	logic [WORD_W-1:0] shadow_words[STACK_WORDS];
	int                low_count = 0;
	int                high_count = 0;

	dual_stack_shared_memory #(
		.DEPTH(STACK_WORDS),
		.WORD_BITS(WORD_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always #2 clk = ~clk;

	function automatic logic [VALUE_W-1:0] widen_word(logic [WORD_W-1:0] w);
		logic [VALUE_W+WORD_W-1:0] ext;
		ext = {{VALUE_W{w[WORD_W-1]}}, w};
		return ext[VALUE_W-1:0];
	endfunction

	// Apply one command to the shadow stacks and return its result
	function automatic rsp_t next_stack_result(req_t r);
		rsp_t rsp;
		rsp.pop_value = '0;
		rsp.status    = ST_DONE;
		case (cmd_t'(r.command))
			CMD_PUSH_A, CMD_PUSH_B: begin
				if (low_count + high_count >= STACK_WORDS) begin
					rsp.status = ST_OVERFLOW;
				end else if (cmd_t'(r.command) == CMD_PUSH_A) begin
					shadow_words[low_count] = r.push_value[WORD_W-1:0];
					low_count++;
				end else begin
					shadow_words[STACK_WORDS-1-high_count] = r.push_value[WORD_W-1:0];
					high_count++;
				end
			end
			CMD_POP_A: begin
				if (low_count == 0) begin
					rsp.pop_value = UNDERFLOW_VALUE;
					rsp.status    = ST_UNDERFLOW;
				end else begin
					low_count--;
					rsp.pop_value = widen_word(shadow_words[low_count]);
				end
			end
			default: begin
				if (high_count == 0) begin
					rsp.pop_value = UNDERFLOW_VALUE;
					rsp.status    = ST_UNDERFLOW;
				end else begin
					rsp.pop_value = widen_word(shadow_words[STACK_WORDS-high_count]);
					high_count--;
				end
			end
		endcase
		return rsp;
	endfunction

	function automatic logic [VALUE_W-1:0] pick_word();
		case ($urandom_range(6, 0))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '1;
			3: return '0;
			4: return 32'($urandom_range(255, 0)) - 32'd128;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_command(cmd_t cmd, logic [VALUE_W-1:0] value, bit drain);
		stack_cmd_t c;
		c.req.command    = cmd;
		c.req.push_value = value;
		c.drain_first    = drain;
		command_queue.push_back(c);
	endtask

	// Driver: change inputs on the falling edge, hold start until the transfer
	always @(negedge clk) begin
		req_t next_req;
		logic next_start;
		stack_cmd_t c;
		if (arst_n) begin
			next_start = start;
			next_req   = request;
			if (!start || taken) begin
				next_start         = 1'b0;
				next_req.command   = 2'($urandom_range(3, 0));
				next_req.push_value = $urandom;
				if (gap_left > 0) begin
					gap_left--;
				end else if (command_queue.size() > 0 &&
						!(command_queue[0].drain_first && awaited_results.size() > 0)) begin
					c          = command_queue.pop_front();
					next_start = 1'b1;
					next_req   = c.req;
					burst_left--;
					if (burst_left <= 0) begin
						if ($urandom_range(3, 0) == 0) begin
							burst_left = $urandom_range(120, 40);
							gap_left   = 0;
						end else begin
							burst_left = $urandom_range(12, 1);
							gap_left   = $urandom_range(8, 1);
						end
					end
				end
			end
			start   <= next_start;
			request <= next_req;
		end
	end

	// Monitor: predict on each accepted command, check each result strobe
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			taken <= (start === 1'b1 && busy === 1'b0);
			if (start === 1'b1 && busy === 1'b0)
				awaited_results.push_back(next_stack_result(request));
			if (done === 1'b1) begin
				if (awaited_results.size() == 0) begin
					$error("result transfer with no command outstanding");
					mismatch_count++;
				end else begin
					want = awaited_results.pop_front();
					if (result.pop_value !== want.pop_value) begin
						$error("pop_value: expected %0d, actual %0d",
							want.pop_value, result.pop_value);
						mismatch_count++;
					end
					if (result.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, result.status);
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin
		int issued;
		int phase_len;
		int push_pct;
		bit drain;
		cmd_t cmd;

		// Empty pops, extreme words, then fill the array and push into it full
		queue_command(CMD_POP_A, 32'h7fff_ffff, 1'b0);
		queue_command(CMD_POP_B, 32'h8000_0000, 1'b0);
		queue_command(CMD_PUSH_A, 32'h7fff_ffff, 1'b0);
		queue_command(CMD_PUSH_B, 32'h8000_0000, 1'b0);
		queue_command(CMD_POP_A, '1, 1'b0);
		queue_command(CMD_POP_B, '0, 1'b0);
		for (int i = 0; i < STACK_WORDS; i++)
			queue_command(i[0] ? CMD_PUSH_B : CMD_PUSH_A, pick_word(), 1'b0);
		queue_command(CMD_PUSH_A, '1, 1'b0);
		queue_command(CMD_PUSH_B, 32'h8000_0000, 1'b0);
		queue_command(CMD_POP_B, $urandom, 1'b0);

		// Random phases biased toward filling, churning or emptying the stacks
		issued = 0;
		drain  = 1'b1;
		while (issued < RANDOM_CMDS) begin
			case ($urandom_range(2, 0))
				0: push_pct = 5;
				1: push_pct = 50;
				default: push_pct = 95;
			endcase
			phase_len = $urandom_range(90, 20);
			for (int i = 0; i < phase_len; i++) begin
				if ($urandom_range(99, 0) < push_pct)
					cmd = $urandom_range(1, 0) ? CMD_PUSH_B : CMD_PUSH_A;
				else
					cmd = $urandom_range(1, 0) ? CMD_POP_B : CMD_POP_A;
				queue_command(cmd, pick_word(), drain);
				drain = 1'b0;
				issued++;
			end
			drain = ($urandom_range(3, 0) == 0);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (command_queue.size() > 0 || start === 1'b1)
			@(posedge clk);
		while (awaited_results.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/dssm_pkg.sv
rtl/dssm_ram.sv
rtl/dssm_ctrl.sv
rtl/dual_stack_shared_memory.sv
tb/sv/dual_stack_shared_memory_test.sv
